>>> src/llfh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// llfh_pkg - shared types and constants of the light level filter
// Field widths, conversion scale, state encoding and register indexes.
// ----------------------------------------------------------------------------
package llfh_pkg;

  localparam int RAW_W        = 16;
  localparam int LUX_W        = 24;
  localparam int ACC_W        = 32;
  localparam int WEIGHT_W     = 9;
  localparam int DIGIT_BITS   = 2;
  localparam int CONV_STEPS   = RAW_W / DIGIT_BITS;
  localparam int FILT_STEPS   = WEIGHT_W;
  localparam int CNT_W        = $clog2(FILT_STEPS);
  localparam int SCALE_W      = 18;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam int FRAC_BITS_DEFAULT = 8;
  localparam int ON_LUX            = 20;
  localparam int OFF_LUX           = 80;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 9'd256;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 9'd77;
  localparam logic [SCALE_W-1:0]  LUX_SCALE     = 18'd54613;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREP,
    ST_FILT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REG_WEIGHT = 2'd0,
    REG_ON     = 2'd1,
    REG_OFF    = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  // one radix-4 digit times the lux scale
  function automatic logic [SCALE_W-1:0] digit_mult(input logic [DIGIT_BITS-1:0] d);
    logic [SCALE_W-1:0] r;
    case (d)
      2'd0:    r = '0;
      2'd1:    r = LUX_SCALE;
      2'd2:    r = LUX_SCALE << 1;
      default: r = (LUX_SCALE << 1) + LUX_SCALE;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/light_level_filter_hysteresis_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// light_level_filter_hysteresis_unit - filtered lux and lamp switch
// Converts raw sensor counts to lux, low-pass filters them and drives a
// hysteresis lamp switch.
// ----------------------------------------------------------------------------
// One raw count is taken per transfer and gives one result of filtered lux
// (unsigned, FRAC_BITS fraction bits) and lamp state. An item passes through
// the idle state in which it is accepted, the raw-to-lux multiply (one 2-bit
// digit of the count per cycle), a setup step, the filter multiply (one
// weight bit per cycle) and a final step that updates the switch and loads
// the output register; that step waits while the last result is stalled at
// the output. A new item is taken while the last result still waits.
// Registers: 0x0 filter weight (Q1.8, values above 256 act as 256),
// 0x4 lamp-on threshold, 0x8 lamp-off threshold.
module light_level_filter_hysteresis_unit #(
  parameter int FRAC_BITS = llfh_pkg::FRAC_BITS_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [llfh_pkg::ADDR_W-1:0]           paddr,
  input  wire  [llfh_pkg::DATA_W-1:0]           pwdata,
  output logic [llfh_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [llfh_pkg::RAW_W-1:0]            raw_count,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [llfh_pkg::LUX_W-1:0]            filtered_lux,
  output logic                                  lamp_on
);

  localparam int LuxShift = llfh_pkg::RAW_W - FRAC_BITS;
  localparam logic [llfh_pkg::LUX_W-1:0] OnReset  =
    llfh_pkg::LUX_W'(llfh_pkg::ON_LUX << FRAC_BITS);
  localparam logic [llfh_pkg::LUX_W-1:0] OffReset =
    llfh_pkg::LUX_W'(llfh_pkg::OFF_LUX << FRAC_BITS);

  llfh_pkg::state_t state, state_next;

  logic [llfh_pkg::WEIGHT_W-1:0] filter_weight;
  logic [llfh_pkg::LUX_W-1:0]    on_threshold;
  logic [llfh_pkg::LUX_W-1:0]    off_threshold;
  logic [llfh_pkg::LUX_W-1:0]    filter_value;
  logic                          lamp_state;

  logic [llfh_pkg::CNT_W-1:0]    cnt;
  logic [llfh_pkg::RAW_W-1:0]    raw_sh;
  logic [llfh_pkg::ACC_W-1:0]    acc;
  logic [llfh_pkg::LUX_W-1:0]    lux;
  logic [llfh_pkg::LUX_W:0]      lux_sum;
  logic [llfh_pkg::WEIGHT_W-1:0] wa_sh;
  logic [llfh_pkg::WEIGHT_W-1:0] wb_sh;

  logic                          load_item;
  logic                          conv_en;
  logic                          prep_en;
  logic                          filt_en;
  logic                          done_en;
  logic                          out_free;
  logic                          cfg_wr;
  llfh_pkg::reg_idx_t            cfg_idx;

  logic [llfh_pkg::ACC_W-1:0]    lux_wide;
  logic [llfh_pkg::LUX_W-1:0]    lux_conv;
  logic [llfh_pkg::WEIGHT_W-1:0] weight_eff;
  logic [llfh_pkg::LUX_W:0]      filt_addend;
  logic [llfh_pkg::LUX_W-1:0]    filter_next;
  logic                          lamp_next;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = llfh_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      llfh_pkg::REG_WEIGHT: prdata = llfh_pkg::DATA_W'(filter_weight);
      llfh_pkg::REG_ON:     prdata = llfh_pkg::DATA_W'(on_threshold);
      llfh_pkg::REG_OFF:    prdata = llfh_pkg::DATA_W'(off_threshold);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_weight <= llfh_pkg::WEIGHT_RESET;
      on_threshold  <= OnReset;
      off_threshold <= OffReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        llfh_pkg::REG_WEIGHT: filter_weight <= pwdata[llfh_pkg::WEIGHT_W-1:0];
        llfh_pkg::REG_ON:     on_threshold  <= pwdata[llfh_pkg::LUX_W-1:0];
        llfh_pkg::REG_OFF:    off_threshold <= pwdata[llfh_pkg::LUX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      llfh_pkg::ST_IDLE: if (in_valid) state_next = llfh_pkg::ST_CONV;
      llfh_pkg::ST_CONV: begin
        if (cnt == llfh_pkg::CNT_W'(llfh_pkg::CONV_STEPS - 1)) state_next = llfh_pkg::ST_PREP;
      end
      llfh_pkg::ST_PREP: state_next = llfh_pkg::ST_FILT;
      llfh_pkg::ST_FILT: begin
        if (cnt == llfh_pkg::CNT_W'(llfh_pkg::FILT_STEPS - 1)) state_next = llfh_pkg::ST_DONE;
      end
      llfh_pkg::ST_DONE: if (out_free) state_next = llfh_pkg::ST_IDLE;
      default:           state_next = llfh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != llfh_pkg::ST_IDLE);
    load_item = (state == llfh_pkg::ST_IDLE) && in_valid;
    conv_en   = (state == llfh_pkg::ST_CONV);
    prep_en   = (state == llfh_pkg::ST_PREP);
    filt_en   = (state == llfh_pkg::ST_FILT);
    done_en   = (state == llfh_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llfh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  assign lux_wide   = acc >> LuxShift;
  assign lux_conv   = (|lux_wide[llfh_pkg::ACC_W-1:llfh_pkg::LUX_W]) ? '1 :
                      lux_wide[llfh_pkg::LUX_W-1:0];
  assign weight_eff = filter_weight[llfh_pkg::WEIGHT_W-1] ? llfh_pkg::WEIGHT_ONE :
                      filter_weight;
  assign filter_next = acc[llfh_pkg::ACC_W-1:8];

  always_comb begin
    case ({wa_sh[llfh_pkg::WEIGHT_W-1], wb_sh[llfh_pkg::WEIGHT_W-1]})
      2'b10:   filt_addend = {1'b0, lux};
      2'b01:   filt_addend = {1'b0, filter_value};
      2'b11:   filt_addend = lux_sum;
      default: filt_addend = '0;
    endcase
  end

  always_comb begin
    lamp_next = lamp_state;
    if (!lamp_state) begin
      if (filter_next <= on_threshold) lamp_next = 1'b1;
    end else begin
      if (filter_next >= off_threshold) lamp_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      raw_sh <= raw_count;
      acc    <= '0;
      cnt    <= '0;
    end else if (conv_en) begin
      acc    <= {acc[llfh_pkg::ACC_W-3:0], 2'b00} + llfh_pkg::ACC_W'(
                llfh_pkg::digit_mult(raw_sh[llfh_pkg::RAW_W-1 -: llfh_pkg::DIGIT_BITS]));
      raw_sh <= raw_sh << llfh_pkg::DIGIT_BITS;
      cnt    <= cnt + 1'b1;
    end else if (prep_en) begin
      lux     <= lux_conv;
      lux_sum <= {1'b0, lux_conv} + {1'b0, filter_value};
      wa_sh   <= weight_eff;
      wb_sh   <= llfh_pkg::WEIGHT_ONE - weight_eff;
      acc     <= '0;
      cnt     <= '0;
    end else if (filt_en) begin
      acc   <= {acc[llfh_pkg::ACC_W-2:0], 1'b0} + llfh_pkg::ACC_W'(filt_addend);
      wa_sh <= wa_sh << 1;
      wb_sh <= wb_sh << 1;
      cnt   <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_value <= '0;
      lamp_state   <= 1'b0;
      out_valid    <= 1'b0;
    end else if (done_en) begin
      filter_value <= filter_next;
      lamp_state   <= lamp_next;
      out_valid    <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_en) begin
      filtered_lux <= filter_next;
      lamp_on      <= lamp_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(state == llfh_pkg::ST_DONE))
    else $error("result appeared without a finished item");

  a_filter_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(filter_value)) |-> $past(done_en))
    else $error("filter state changed outside item completion");

  a_lamp_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && lamp_state != $past(lamp_state)) |-> $past(done_en))
    else $error("lamp state changed outside item completion");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == llfh_pkg::ST_CONV && cnt == '0))
    else $error("accepted transfer did not start conversion");
`endif

endmodule
`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - light level filter and lamp switch testbench
// Drives raw sensor counts through valid/stall, programs the weight and the
// two thresholds over the register port between phases, and checks every
// filtered lux and lamp state against a cycle-free model or fixed plan values.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC         = llfh_pkg::FRAC_BITS_DEFAULT;
  localparam int RANDOM_ITEMS = 1350;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PLAN_LEN     = 37;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [llfh_pkg::LUX_W-1:0] lux;
    logic                       lamp;
  } lux_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    llfh_pkg::reg_idx_t         idx;
    logic [31:0]                data;
    logic                       typed;
    logic [llfh_pkg::LUX_W-1:0] lux;
    logic                       lamp;
  } row_t;

  typedef enum logic [1:0] {RAW_FULL, RAW_LOW, RAW_NEAR} raw_mix_t;

  logic                          clk;
  logic                          rst       = 1'b1;
  logic                          psel      = 1'b0;
  logic                          penable   = 1'b0;
  logic                          pwrite    = 1'b0;
  logic [llfh_pkg::ADDR_W-1:0]   paddr     = '0;
  logic [llfh_pkg::DATA_W-1:0]   pwdata    = '0;
  logic [llfh_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [llfh_pkg::RAW_W-1:0]    raw_count = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [llfh_pkg::LUX_W-1:0]    filtered_lux;
  logic                          lamp_on;

  // model state and register copies
  logic [llfh_pkg::WEIGHT_W-1:0] cfg_weight;
  logic [llfh_pkg::LUX_W-1:0]    cfg_on;
  logic [llfh_pkg::LUX_W-1:0]    cfg_off;
  logic [llfh_pkg::LUX_W-1:0]    filt_mem;
  logic                          lamp_mem;

  lux_result_t         pending_readings [$];
  lux_result_t         head;
  int                  fail_count  = 0;
  int                  cycle_count = 0;
  int                  stall_left  = 0;
  int                  stall_roll;
  bit                  stall_on    = 1'b1;
  bit                  gaps_on     = 1'b1;
  raw_mix_t            raw_mix     = RAW_FULL;
  int                  raw_center  = 0;

  light_level_filter_hysteresis_unit dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_count    (raw_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filtered_lux (filtered_lux),
    .lamp_on      (lamp_on)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [llfh_pkg::LUX_W-1:0] count_to_lux(
      input logic [llfh_pkg::RAW_W-1:0] c);
    logic [39:0] prod;
    prod = (40'(c) * 40'(llfh_pkg::LUX_SCALE)) >> (16 - FRAC);
    if (prod > 40'hFF_FFFF) return 24'hFF_FFFF;
    return prod[llfh_pkg::LUX_W-1:0];
  endfunction

  function automatic void reset_model();
    cfg_weight = llfh_pkg::WEIGHT_RESET;
    cfg_on     = llfh_pkg::LUX_W'(llfh_pkg::ON_LUX << FRAC);
    cfg_off    = llfh_pkg::LUX_W'(llfh_pkg::OFF_LUX << FRAC);
    filt_mem   = '0;
    lamp_mem   = 1'b0;
  endfunction

  function automatic lux_result_t predict_reading(input logic [llfh_pkg::RAW_W-1:0] c);
    logic [llfh_pkg::WEIGHT_W-1:0] a;
    logic [39:0]                   acc;
    lux_result_t                   r;
    a   = (cfg_weight > llfh_pkg::WEIGHT_ONE) ? llfh_pkg::WEIGHT_ONE : cfg_weight;
    acc = 40'(a) * 40'(count_to_lux(c)) + 40'(llfh_pkg::WEIGHT_ONE - a) * 40'(filt_mem);
    filt_mem = acc[31:8];
    if (!lamp_mem) begin
      if (filt_mem <= cfg_on) lamp_mem = 1'b1;
    end else if (filt_mem >= cfg_off) begin
      lamp_mem = 1'b0;
    end
    r.lux  = filt_mem;
    r.lamp = lamp_mem;
    return r;
  endfunction

  function automatic row_t wr_row(input llfh_pkg::reg_idx_t idx, input logic [31:0] data);
    return '{ROW_WRITE, idx, data, 1'b0, '0, 1'b0};
  endfunction

  function automatic row_t sample_row(input logic [llfh_pkg::RAW_W-1:0] c);
    return '{ROW_SAMPLE, llfh_pkg::REG_NONE, 32'(c), 1'b0, '0, 1'b0};
  endfunction

  function automatic row_t known_row(input logic [llfh_pkg::RAW_W-1:0] c,
                                     input logic [llfh_pkg::LUX_W-1:0] lux,
                                     input logic lamp);
    return '{ROW_SAMPLE, llfh_pkg::REG_NONE, 32'(c), 1'b1, lux, lamp};
  endfunction

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [llfh_pkg::RAW_W-1:0] clamp_count(input int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return llfh_pkg::RAW_W'(v);
  endfunction

  function automatic logic [llfh_pkg::RAW_W-1:0] next_raw();
    int spread;
    case (raw_mix)
      RAW_LOW: return llfh_pkg::RAW_W'($urandom_range(0, 255));
      RAW_NEAR: begin
        spread = $urandom_range(0, 2000);
        return clamp_count(raw_center + $urandom_range(0, 2 * spread) - spread);
      end
      default: return llfh_pkg::RAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    int          r;
    logic [8:0]  w;
    r = $urandom_range(0, 99);
    if (r < 10)      w = 9'd0;
    else if (r < 20) w = 9'd256;
    else if (r < 30) w = 9'($urandom_range(257, 511));
    else if (r < 40) w = 9'd1;
    else if (r < 50) w = 9'd255;
    else             w = 9'($urandom_range(2, 255));
    return ($urandom & ~32'h1FF) | 32'(w);
  endfunction

  task automatic write_reg(input llfh_pkg::reg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      llfh_pkg::REG_WEIGHT: cfg_weight = data[llfh_pkg::WEIGHT_W-1:0];
      llfh_pkg::REG_ON:     cfg_on     = data[llfh_pkg::LUX_W-1:0];
      llfh_pkg::REG_OFF:    cfg_off    = data[llfh_pkg::LUX_W-1:0];
      default:              ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // drop valid and wait until every reading has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic pause();
    int g;
    g = gaps_on ? gap_length() : 0;
    if (g > 0) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      raw_count <= llfh_pkg::RAW_W'($urandom_range(0, 65535));
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_sample(input logic [llfh_pkg::RAW_W-1:0] c, input logic typed,
                             input logic [llfh_pkg::LUX_W-1:0] lux, input logic lamp);
    lux_result_t r;
    @(negedge clk);
    in_valid  <= 1'b1;
    raw_count <= c;
    do @(posedge clk); while (in_stall);
    r = predict_reading(c);
    if (typed) begin
      r.lux  = lux;
      r.lamp = lamp;
    end
    pending_readings.push_back(r);
  endtask

  task automatic pick_thresholds();
    int                         r;
    logic [llfh_pkg::LUX_W-1:0] lo;
    logic [llfh_pkg::LUX_W-1:0] hi;
    logic [llfh_pkg::LUX_W-1:0] on_v;
    logic [llfh_pkg::LUX_W-1:0] off_v;
    r  = $urandom_range(0, 99);
    lo = count_to_lux(clamp_count(raw_center - $urandom_range(0, 1500)));
    hi = count_to_lux(clamp_count(raw_center + $urandom_range(0, 1500)));
    if (r < 10) begin
      on_v  = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
      off_v = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd0;
    end else if (r < 25) begin
      on_v  = hi;
      off_v = lo;
    end else begin
      on_v  = lo;
      off_v = hi;
    end
    if ($urandom_range(0, 9) < 8) write_reg(llfh_pkg::REG_ON, {8'($urandom), on_v});
    if ($urandom_range(0, 9) < 8) write_reg(llfh_pkg::REG_OFF, {8'($urandom), off_v});
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 7);
      end else if (stall_roll < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_MAX)
          $display("unexpected transfer: lux %0d lamp %0b", filtered_lux, lamp_on);
      end else begin
        head = pending_readings.pop_front();
        if (filtered_lux !== head.lux || lamp_on !== head.lamp) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: expected lux %0d lamp %0b, got lux %0d lamp %0b",
                     head.lux, head.lamp, filtered_lux, lamp_on);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t plan [PLAN_LEN];
    int   random_sent;
    int   n;
    plan = '{
      known_row(16'd0, 24'd0, 1'b1),
      wr_row(llfh_pkg::REG_WEIGHT, 32'd256),
      known_row(16'hFFFF, 24'd13980714, 1'b0),
      known_row(16'd1, 24'd213, 1'b1),
      known_row(16'd0, 24'd0, 1'b1),
      wr_row(llfh_pkg::REG_WEIGHT, 32'd0),
      known_row(16'hFFFF, 24'd0, 1'b1),
      wr_row(llfh_pkg::REG_WEIGHT, 32'hFFFF_FFFF),
      known_row(16'hFFFF, 24'd13980714, 1'b0),
      wr_row(llfh_pkg::REG_WEIGHT, 32'd257),
      known_row(16'd0, 24'd0, 1'b1),
      wr_row(llfh_pkg::REG_ON, 32'd30000),
      wr_row(llfh_pkg::REG_OFF, 32'd10000),
      known_row(16'd94, 24'd20053, 1'b0),
      known_row(16'd94, 24'd20053, 1'b1),
      known_row(16'd94, 24'd20053, 1'b0),
      wr_row(llfh_pkg::REG_ON, 32'd0),
      wr_row(llfh_pkg::REG_OFF, 32'h00FF_FFFF),
      known_row(16'd0, 24'd0, 1'b1),
      known_row(16'hFFFF, 24'd13980714, 1'b1),
      wr_row(llfh_pkg::REG_ON, 32'hFFFF_FFFF),
      wr_row(llfh_pkg::REG_OFF, 32'd0),
      known_row(16'hFFFF, 24'd13980714, 1'b0),
      known_row(16'hFFFF, 24'd13980714, 1'b1),
      wr_row(llfh_pkg::REG_ON, 32'd213),
      wr_row(llfh_pkg::REG_OFF, 32'd426),
      sample_row(16'd2),
      sample_row(16'd1),
      wr_row(llfh_pkg::REG_NONE, 32'd0),
      sample_row(16'd2),
      wr_row(llfh_pkg::REG_WEIGHT, 32'd1),
      sample_row(16'hFFFF),
      sample_row(16'hAAAA),
      wr_row(llfh_pkg::REG_WEIGHT, 32'd77),
      sample_row(16'h5555),
      sample_row(16'hFFFF),
      sample_row(16'd12345)
    };
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        pause();
        send_sample(plan[i].data[llfh_pkg::RAW_W-1:0], plan[i].typed, plan[i].lux,
                    plan[i].lamp);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      raw_center = $urandom_range(0, 65535);
      raw_mix    = raw_mix_t'($urandom_range(0, 2));
      if ($urandom_range(0, 9) < 6) write_reg(llfh_pkg::REG_WEIGHT, pick_weight());
      if ($urandom_range(0, 9) < 7) pick_thresholds();
      if ($urandom_range(0, 19) == 0) write_reg(llfh_pkg::REG_NONE, $urandom);
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 120);
      if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
      repeat (n) begin
        pause();
        send_sample(next_raw(), 1'b0, '0, 1'b0);
        random_sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
